### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL; they compile away under
// SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, p) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, p)
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)

`endif

`endif

### sv/sxpd_pkg.sv
// ----------------------------------------------------------------------------
// sxpd_pkg
// Types and constants of the sync-byte packet deframer: byte positions
// within a packet, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sxpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [PosW-1:0]    byte_pos_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Position of the next expected byte within a packet.
  localparam byte_pos_t PosHunt   = 4'd0;
  localparam byte_pos_t PosSecond = 4'd1;
  localparam byte_pos_t PosType   = 4'd2;
  localparam byte_pos_t PosFlag   = 4'd3;
  localparam byte_pos_t PosXHi    = 4'd4;
  localparam byte_pos_t PosXLo    = 4'd5;
  localparam byte_pos_t PosYHi    = 4'd6;
  localparam byte_pos_t PosYLo    = 4'd7;
  localparam byte_pos_t PosRadHi  = 4'd8;
  localparam byte_pos_t PosRadLo  = 4'd9;
  localparam byte_pos_t PosDistHi = 4'd10;
  localparam byte_pos_t PosDistLo = 4'd11;
  localparam byte_pos_t PosCheck  = 4'd12;

  // Configuration register indexes.
  localparam cfg_idx_t CfgFirstSync  = 2'd0;
  localparam cfg_idx_t CfgSecondSync = 2'd1;
  localparam cfg_idx_t CfgDetectType = 2'd2;

  // Configuration reset values.
  localparam byte_t FirstSyncRst  = 8'd170;
  localparam byte_t SecondSyncRst = 8'd85;
  localparam byte_t DetectTypeRst = 8'd1;

endpackage

`default_nettype wire

### sv/sync_xor_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_xor_packet_deframer_core
// Hunts for 13-byte sync-framed packets with an XOR check byte and reports
// the fields of each valid detection packet.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on rx_byte_i with in_valid_i; a byte is taken
// at a clock edge where in_valid_i is high and in_stall_o is low. Every byte
// is handled as taken, so one byte per unstalled cycle is sustained. A packet is
// two sync bytes, type, flag, four big-endian 16-bit words and a check byte
// equal to the XOR of the type byte through the last word byte.
// When the check byte of a packet arrives and both the checksum and the type
// match, one result appears on the output channel in the following cycle
// and holds while out_stall_i is high. Bytes that give no result keep flowing
// while a result waits; only a check byte is held off by in_stall_o while an
// earlier result is still stalled at the output register.
// Configuration writes (first sync, second sync, detection type) are taken
// on the cfg channel in any cycle; cfg_ready_o is always high. They are
// meant to be written while no packet is in progress.
// Reset returns the block to hunting for the first sync byte, clears the
// running checksum and the output valid, and loads the sync and type
// registers with 170, 85 and 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sync_xor_packet_deframer_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire sxpd_pkg::cfg_idx_t      cfg_index_i,
  input  wire sxpd_pkg::byte_t         cfg_data_i,

  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire sxpd_pkg::byte_t         rx_byte_i,

  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic                    target_present_o,
  output      sxpd_pkg::word_t         x_position_o,
  output      sxpd_pkg::word_t         y_position_o,
  output      sxpd_pkg::word_t         radius_pixels_o,
  output      sxpd_pkg::word_t         distance_mm_o
);

  // Configuration registers.
  sxpd_pkg::byte_t first_sync_q, second_sync_q, detect_type_q;
  logic            cfg_we;

  // Framing state.
  sxpd_pkg::byte_pos_t byte_pos_q, byte_pos_d;
  sxpd_pkg::byte_t     xor_q, xor_d;

  // Packet fields captured as their bytes arrive.
  sxpd_pkg::byte_t type_q;
  logic            flag_q;
  sxpd_pkg::word_t x_q, y_q, rad_q, dist_q;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            result_hit;
  logic            in_accept, out_accept;
  logic            at_check;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q  <= sxpd_pkg::FirstSyncRst;
      second_sync_q <= sxpd_pkg::SecondSyncRst;
      detect_type_q <= sxpd_pkg::DetectTypeRst;
    end else if (cfg_we) begin
      case (cfg_index_i)
        sxpd_pkg::CfgFirstSync:  first_sync_q  <= cfg_data_i;
        sxpd_pkg::CfgSecondSync: second_sync_q <= cfg_data_i;
        sxpd_pkg::CfgDetectType: detect_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Only a check byte can produce a result, so only it waits for room.
  assign at_check   = (byte_pos_q == sxpd_pkg::PosCheck);
  assign in_stall_o = at_check & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_q & ~out_stall_i;

  always_comb begin
    byte_pos_d = byte_pos_q;
    xor_d      = xor_q;
    result_hit = 1'b0;
    if (in_accept) begin
      case (byte_pos_q)
        sxpd_pkg::PosSecond: begin
          if (rx_byte_i == second_sync_q) begin
            byte_pos_d = sxpd_pkg::PosType;
            xor_d      = '0;
          end else if (rx_byte_i == first_sync_q) begin
            byte_pos_d = sxpd_pkg::PosSecond;
          end else begin
            byte_pos_d = sxpd_pkg::PosHunt;
          end
        end
        sxpd_pkg::PosType, sxpd_pkg::PosFlag,
        sxpd_pkg::PosXHi, sxpd_pkg::PosXLo,
        sxpd_pkg::PosYHi, sxpd_pkg::PosYLo,
        sxpd_pkg::PosRadHi, sxpd_pkg::PosRadLo,
        sxpd_pkg::PosDistHi, sxpd_pkg::PosDistLo: begin
          xor_d      = xor_q ^ rx_byte_i;
          byte_pos_d = byte_pos_q + sxpd_pkg::byte_pos_t'(1);
        end
        sxpd_pkg::PosCheck: begin
          byte_pos_d = sxpd_pkg::PosHunt;
          result_hit = (rx_byte_i == xor_q) && (type_q == detect_type_q);
        end
        default: begin
          // Hunting, and any position past the check byte is treated alike.
          byte_pos_d = (rx_byte_i == first_sync_q) ? sxpd_pkg::PosSecond
                                                   : sxpd_pkg::PosHunt;
        end
      endcase
    end
  end

  assign out_valid_d = result_hit | (out_valid_q & ~out_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= sxpd_pkg::PosHunt;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Field capture; each register is written only at its own byte position.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      case (byte_pos_q)
        sxpd_pkg::PosType:   type_q          <= rx_byte_i;
        sxpd_pkg::PosFlag:   flag_q          <= (rx_byte_i != '0);
        sxpd_pkg::PosXHi:    x_q[15:8]       <= rx_byte_i;
        sxpd_pkg::PosXLo:    x_q[7:0]        <= rx_byte_i;
        sxpd_pkg::PosYHi:    y_q[15:8]       <= rx_byte_i;
        sxpd_pkg::PosYLo:    y_q[7:0]        <= rx_byte_i;
        sxpd_pkg::PosRadHi:  rad_q[15:8]     <= rx_byte_i;
        sxpd_pkg::PosRadLo:  rad_q[7:0]      <= rx_byte_i;
        sxpd_pkg::PosDistHi: dist_q[15:8]    <= rx_byte_i;
        sxpd_pkg::PosDistLo: dist_q[7:0]     <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // Result payload register, loaded only when a new result is made.
  logic            res_flag_q;
  sxpd_pkg::word_t res_x_q, res_y_q, res_rad_q, res_dist_q;

  always_ff @(posedge clk_i) begin
    if (result_hit) begin
      res_flag_q <= flag_q;
      res_x_q    <= x_q;
      res_y_q    <= y_q;
      res_rad_q  <= rad_q;
      res_dist_q <= dist_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign target_present_o = res_flag_q;
  assign x_position_o     = res_x_q;
  assign y_position_o     = res_y_q;
  assign radius_pixels_o  = res_rad_q;
  assign distance_mm_o    = res_dist_q;

  `ASSERT_ALWAYS(a_pos_in_range, clk_i, rst_ni,
                 byte_pos_q <= sxpd_pkg::PosCheck)
  `ASSERT_NEXT(a_check_returns_to_hunt, clk_i, rst_ni,
               in_accept && at_check, byte_pos_q == sxpd_pkg::PosHunt)
  `ASSERT_IMPL(a_result_from_check_byte, clk_i, rst_ni, $rose(out_valid_q),
               $past(in_accept) && ($past(byte_pos_q) == sxpd_pkg::PosCheck))
  `ASSERT_NEXT(a_sync_clears_xor, clk_i, rst_ni,
               in_accept && (byte_pos_q == sxpd_pkg::PosSecond) &&
               (rx_byte_i == second_sync_q), xor_q == '0)
  `ASSERT_IMPL(a_no_result_overwrite, clk_i, rst_ni,
               result_hit, !(out_valid_q && out_stall_i))

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: sync_xor_packet_deframer_core testbench
// Drives received bytes through the deframer with random idling on both
// channels and checks every detection result against a cycle-free model of
// the framing, checksum and type rules. Sync and type registers are
// reloaded between phases, including equal sync bytes and all-zero and
// all-one settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 3000;
  localparam int PhaseBytes = 115;

  typedef struct packed {
    logic            target_present;
    sxpd_pkg::word_t x_position;
    sxpd_pkg::word_t y_position;
    sxpd_pkg::word_t radius_pixels;
    sxpd_pkg::word_t distance_mm;
  } detection_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  sxpd_pkg::cfg_idx_t cfg_index_i;
  sxpd_pkg::byte_t    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  sxpd_pkg::byte_t    rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               target_present_o;
  sxpd_pkg::word_t    x_position_o;
  sxpd_pkg::word_t    y_position_o;
  sxpd_pkg::word_t    radius_pixels_o;
  sxpd_pkg::word_t    distance_mm_o;

  sync_xor_packet_deframer_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_present_o (target_present_o),
    .x_position_o     (x_position_o),
    .y_position_o     (y_position_o),
    .radius_pixels_o  (radius_pixels_o),
    .distance_mm_o    (distance_mm_o)
  );

  // Mirror of the block's registers and framing state.
  sxpd_pkg::byte_t     mirror_first_sync;
  sxpd_pkg::byte_t     mirror_second_sync;
  sxpd_pkg::byte_t     mirror_detect_type;
  sxpd_pkg::byte_pos_t frame_pos;
  sxpd_pkg::byte_t     frame_bytes [13];
  sxpd_pkg::byte_t     frame_xor;

  detection_t expected_detections [$];
  int         error_count;
  int         bytes_sent;
  int         send_idle_pct;
  int         stall_pct;
  int         quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Follows one accepted byte through the framing rules and queues the
  // detection that a completed, valid packet produces.
  function automatic void track_rx_byte(input sxpd_pkg::byte_t b);
    detection_t          det;
    sxpd_pkg::byte_pos_t pos;
    pos = (frame_pos > sxpd_pkg::PosCheck) ? sxpd_pkg::PosHunt : frame_pos;
    if (pos == sxpd_pkg::PosHunt) begin
      if (b == mirror_first_sync) begin
        frame_bytes[sxpd_pkg::PosHunt] = b;
        frame_pos = sxpd_pkg::PosSecond;
      end
    end else if (pos == sxpd_pkg::PosSecond) begin
      // The second-sync comparison takes precedence when both syncs match.
      if (b == mirror_second_sync) begin
        frame_bytes[sxpd_pkg::PosSecond] = b;
        frame_xor = '0;
        frame_pos = sxpd_pkg::PosType;
      end else begin
        frame_pos = (b == mirror_first_sync) ? sxpd_pkg::PosSecond
                                             : sxpd_pkg::PosHunt;
      end
    end else begin
      frame_bytes[pos] = b;
      if (pos != sxpd_pkg::PosCheck) begin
        frame_xor = frame_xor ^ b;
        frame_pos = sxpd_pkg::byte_pos_t'(pos + 1);
      end else begin
        frame_pos = sxpd_pkg::PosHunt;
        if (b == frame_xor &&
            frame_bytes[sxpd_pkg::PosType] == mirror_detect_type) begin
          det.target_present = (frame_bytes[sxpd_pkg::PosFlag] != '0);
          det.x_position     = {frame_bytes[sxpd_pkg::PosXHi],
                                frame_bytes[sxpd_pkg::PosXLo]};
          det.y_position     = {frame_bytes[sxpd_pkg::PosYHi],
                                frame_bytes[sxpd_pkg::PosYLo]};
          det.radius_pixels  = {frame_bytes[sxpd_pkg::PosRadHi],
                                frame_bytes[sxpd_pkg::PosRadLo]};
          det.distance_mm    = {frame_bytes[sxpd_pkg::PosDistHi],
                                frame_bytes[sxpd_pkg::PosDistLo]};
          expected_detections.push_back(det);
        end
      end
    end
  endfunction

  function automatic sxpd_pkg::byte_t pick_data_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return sxpd_pkg::byte_t'($urandom_range(255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input sxpd_pkg::byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    track_rx_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input sxpd_pkg::byte_t body [10], input bit bad_check);
    sxpd_pkg::byte_t check;
    check = '0;
    foreach (body[i]) check = check ^ body[i];
    if (bad_check) check = check ^ sxpd_pkg::byte_t'($urandom_range(255, 1));
    send_byte(mirror_first_sync);
    send_byte(mirror_second_sync);
    foreach (body[i]) send_byte(body[i]);
    send_byte(check);
  endtask

  task automatic send_random_frame(input sxpd_pkg::byte_t type_code,
                                   input bit bad_check);
    sxpd_pkg::byte_t body [10];
    body[0] = type_code;
    body[1] = $urandom_range(1) ? 8'h00 : pick_data_byte();
    for (int i = 2; i < 10; i++) body[i] = pick_data_byte();
    send_frame(body, bad_check);
  endtask

  // Completes any partial packet with bytes that match neither sync value.
  task automatic finish_frame();
    sxpd_pkg::byte_t filler;
    filler = 8'h00;
    while (filler == mirror_first_sync || filler == mirror_second_sync) filler++;
    while (frame_pos != sxpd_pkg::PosHunt) send_byte(filler);
  endtask

  task automatic wait_for_detections();
    in_valid_i <= 1'b0;
    while (expected_detections.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input sxpd_pkg::cfg_idx_t idx,
                           input sxpd_pkg::byte_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sxpd_pkg::CfgFirstSync:  mirror_first_sync  = value;
      sxpd_pkg::CfgSecondSync: mirror_second_sync = value;
      sxpd_pkg::CfgDetectType: mirror_detect_type = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Registers only change with the deframer hunting and the output empty.
  task automatic load_config(input sxpd_pkg::byte_t first_sync,
                             input sxpd_pkg::byte_t second_sync,
                             input sxpd_pkg::byte_t detect_type);
    finish_frame();
    wait_for_detections();
    write_reg(sxpd_pkg::CfgFirstSync, first_sync);
    write_reg(sxpd_pkg::CfgSecondSync, second_sync);
    write_reg(sxpd_pkg::CfgDetectType, detect_type);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
  endtask

  // Mostly well-formed packets, with corrupted check bytes, foreign types
  // and bursts of line noise that may contain stray sync bytes.
  task automatic run_random_traffic(input int n_bytes);
    int              stop_at;
    int              n_noise;
    int              pick;
    sxpd_pkg::byte_t noise;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_random_frame(mirror_detect_type, 1'b0);
      end else if (pick < 68) begin
        send_random_frame(mirror_detect_type, 1'b1);
      end else if (pick < 80) begin
        send_random_frame(mirror_detect_type ^
                          sxpd_pkg::byte_t'($urandom_range(255, 1)), 1'b0);
      end else begin
        n_noise = $urandom_range(6, 1);
        repeat (n_noise) begin
          case ($urandom_range(7))
            0, 1:    noise = mirror_first_sync;
            2:       noise = mirror_second_sync;
            default: noise = sxpd_pkg::byte_t'($urandom_range(255));
          endcase
          send_byte(noise);
        end
      end
    end
  endtask

  task automatic test_directed_framing();
    // Hunting drops both extremes, then a doubled first sync resynchronizes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mirror_first_sync);
    send_frame('{sxpd_pkg::DetectTypeRst, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                 8'h80, 8'h01, 8'h7F, 8'hFE}, 1'b0);
    // A wrong second byte that is not a first sync returns to hunting.
    send_byte(mirror_first_sync);
    send_byte(8'h00);
    send_frame('{sxpd_pkg::DetectTypeRst, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
                 8'h9A, 8'hBC, 8'hDE, 8'hF0}, 1'b1);
    wait_for_detections();
  endtask

  task automatic test_default_traffic();
    run_random_traffic(PhaseBytes);
  endtask

  task automatic test_low_config();
    load_config(8'h00, 8'hFF, 8'h00);
    run_random_traffic(PhaseBytes);
  endtask

  task automatic test_high_config();
    load_config(8'hFF, 8'h00, 8'hFF);
    run_random_traffic(PhaseBytes);
  endtask

  task automatic test_equal_sync_config();
    load_config(8'h5A, 8'h5A, sxpd_pkg::byte_t'($urandom_range(255)));
    run_random_traffic(PhaseBytes);
  endtask

  task automatic test_random_config();
    load_config(sxpd_pkg::byte_t'($urandom_range(255)),
                sxpd_pkg::byte_t'($urandom_range(255)),
                sxpd_pkg::byte_t'($urandom_range(255)));
    run_random_traffic(PhaseBytes);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_detections
    detection_t exp_det;
    detection_t got_det;
    logic [15:0] exp_f [5];
    logic [15:0] got_f [5];
    string       f_name [5];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_det = '{target_present_o, x_position_o, y_position_o,
                  radius_pixels_o, distance_mm_o};
      if (expected_detections.size() == 0) begin
        $display("%0t: unexpected detection %p", $time, got_det);
        error_count++;
      end else begin
        exp_det = expected_detections.pop_front();
        f_name = '{"target_present", "x_position", "y_position",
                   "radius_pixels", "distance_mm"};
        exp_f = '{16'(exp_det.target_present), exp_det.x_position,
                  exp_det.y_position, exp_det.radius_pixels, exp_det.distance_mm};
        got_f = '{16'(got_det.target_present), got_det.x_position,
                  got_det.y_position, got_det.radius_pixels, got_det.distance_mm};
        for (int i = 0; i < 5; i++) begin
          if (exp_f[i] !== got_f[i]) begin
            $display("%0t: %s expected %0d, got %0d", $time, f_name[i],
                     exp_f[i], got_f[i]);
            error_count++;
          end
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = sxpd_pkg::CfgFirstSync;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    rx_byte_i          = '0;
    out_stall_i        = 1'b0;
    mirror_first_sync  = sxpd_pkg::FirstSyncRst;
    mirror_second_sync = sxpd_pkg::SecondSyncRst;
    mirror_detect_type = sxpd_pkg::DetectTypeRst;
    frame_pos          = sxpd_pkg::PosHunt;
    frame_xor          = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    error_count        = 0;
    bytes_sent         = 0;
    quiet_cycles       = 0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idling(38, 69);
    test_directed_framing();
    test_default_traffic();
    test_low_config();
    set_idling(69, 38);
    test_high_config();
    test_equal_sync_config();
    set_idling(0, 0);
    test_random_config();

    wait_for_detections();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_detections.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sync_xor_packet_deframer_core.f
+incdir+sv
sv/sxpd_pkg.sv
sv/sync_xor_packet_deframer_core.sv
sim/tb.sv
